[hdl/rpli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rpli_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int EW         = 5;
	localparam int RECIP_W    = 25;
	localparam int RECIP_SH   = 24;

	localparam logic [CFG_IDX_W-1:0] REG_INTERP_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENCODER_MAX  = 1'd1;

	typedef enum logic [1:0] {
		MODE_DECIDE = 2'd0,
		MODE_PASS   = 2'd1,
		MODE_INTERP = 2'd2,
		MODE_DROP   = 2'd3
	} mode_t;

	typedef struct packed {
		logic        start;
		logic [15:0] a;
		logic [15:0] b;
		logic [16:0] t;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] ra;
		logic [15:0] rb;
	} mod_rsp_t;

	// ceil(2^24 / e), exact floor division for dividends below 2^20
	function automatic logic [RECIP_W-1:0] recip(input logic [EW-1:0] e);
		logic [RECIP_W-1:0] m;
		case (e)
			5'd1:    m = 25'd16777216;
			5'd2:    m = 25'd8388608;
			5'd3:    m = 25'd5592406;
			5'd4:    m = 25'd4194304;
			5'd5:    m = 25'd3355444;
			5'd6:    m = 25'd2796203;
			5'd7:    m = 25'd2396746;
			5'd8:    m = 25'd2097152;
			5'd9:    m = 25'd1864136;
			5'd10:   m = 25'd1677722;
			5'd11:   m = 25'd1525202;
			5'd12:   m = 25'd1398102;
			5'd13:   m = 25'd1290556;
			5'd14:   m = 25'd1198373;
			5'd15:   m = 25'd1118482;
			5'd16:   m = 25'd1048576;
			default: m = 25'd16777216;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

[hdl/rpli_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rpli_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic        [15:0] azimuth;
	logic               pulse_end;

	modport source (output valid, output sample, output azimuth, output pulse_end, input ready);
	modport sink (input valid, input sample, input azimuth, input pulse_end, output ready);
endinterface

interface rpli_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value;
	logic        [15:0] out_azimuth;
	logic        [3:0]  copy_index;
	logic               at_pulse_end;
	logic               last;

	modport source (output valid, output value, output out_azimuth, output copy_index,
		output at_pulse_end, output last, input ready);
	modport sink (input valid, input value, input out_azimuth, input copy_index,
		input at_pulse_end, input last, output ready);
endinterface
`default_nettype wire

[hdl/rpli_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpli_mod (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpli_pkg::mod_req_t req,
	output rpli_pkg::mod_rsp_t      rsp
);
	import rpli_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] da_q;
	logic [15:0] db_q;
	logic [16:0] ra_q;
	logic [16:0] rb_q;
	logic [16:0] t_q;
	logic [16:0] sa;
	logic [16:0] sb;
	logic [16:0] ra_n;
	logic [16:0] rb_n;

	// one remainder bit per cycle for both dividends
	always_comb begin
		sa   = {ra_q[15:0], da_q[15]};
		sb   = {rb_q[15:0], db_q[15]};
		ra_n = (sa >= t_q) ? sa - t_q : sa;
		rb_n = (sb >= t_q) ? sb - t_q : sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			da_q <= req.a;
			db_q <= req.b;
			t_q  <= req.t;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			da_q <= {da_q[14:0], 1'b0};
			db_q <= {db_q[14:0], 1'b0};
			ra_q <= ra_n;
			rb_q <= rb_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.ra   = ra_q[15:0];
	assign rsp.rb   = rb_q[15:0];
endmodule
`default_nettype wire

[hdl/radar_pulse_linear_interpolator.sv]
// Sequence: once an item is accepted, the serial azimuth remainder unit, handoff and decode run,
// then each result passes through blend, divide and round (pass-through skips blend and divide).
// A new item is taken only once the last one is fully done (all results emitted, state updated);
// the pace is set by the serial remainder unit, the per-copy sequence and output stalls.
// Reset: asynchronous active low; clears control state and the configuration registers to their defaults.
// The line store is not cleared; entries read before being written are undefined.
`timescale 1ns / 1ps
`default_nettype none
module radar_pulse_linear_interpolator #(
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_COPIES  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [rpli_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [rpli_pkg::CFG_DATA_W-1:0] wr_data,
	rpli_in_if.sink                             din,
	rpli_out_if.source                          dout
);
	import rpli_pkg::*;

	localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int PW   = $clog2(MAX_SAMPLES + 1);
	localparam int EMAX = (MAX_COPIES < 16) ? MAX_COPIES : 16;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MODW = 7'b0000010,
		ST_DEC  = 7'b0000100,
		ST_N1   = 7'b0001000,
		ST_N2   = 7'b0010000,
		ST_N3   = 7'b0100000,
		ST_UPD  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [3:0]  interp_count_q;
	logic [15:0] encoder_max_q;
	logic [15:0] prior_az_q;
	logic        have_prior_q;
	logic [PW-1:0] pos_q;
	mode_t       mode_q;
	mode_t       mode_eff_q;

	logic signed [15:0] s_q;
	logic [15:0] az_q;
	logic        pend_q;
	logic        in_store_q;
	logic signed [15:0] rdata_q;
	logic signed [15:0] line_mem [MAX_SAMPLES];

	logic signed [17:0] os_q;
	logic [16:0] d_q;
	logic [16:0] t_q;
	logic [21:0] te_q;
	logic [EW-1:0] e_q;
	logic [EW-1:0] k_q;

	logic        vneg_s1;
	logic [19:0] vabs_s1;
	logic [19:0] naz_s1;
	logic [19:0] qv_s2;
	logic [16:0] qa_s2;

	logic        out_valid_q;
	logic signed [15:0] out_value_q;
	logic [15:0] out_az_q;
	logic [3:0]  out_copy_q;
	logic        out_pend_q;
	logic        out_last_q;

	logic        acc_in;
	logic        emit;
	logic        mem_we;
	logic [EW-1:0] e_full;
	logic [EW-1:0] e_val;
	logic [16:0] t_val;
	mod_req_t    mreq;
	mod_rsp_t    mrsp;

	logic [16:0] n_ext;
	logic [16:0] o_ext;
	logic        wrap_neg;
	logic [16:0] d_c;
	logic signed [17:0] os_c;
	logic        drop_c;
	mode_t       mode_c;

	logic [EW-1:0] ek;
	logic signed [21:0] pv;
	logic signed [21:0] ps;
	logic signed [22:0] vsum;
	logic [22:0] vabs_c;
	logic signed [24:0] naz_c;
	logic signed [24:0] naz_w;

	logic [RECIP_W-1:0] m_c;
	logic [44:0] qv_p;
	logic [44:0] qa_p;

	logic [19:0] rem_full;
	logic [EW-1:0] rem_c;
	logic [16:0] qr_c;
	logic [16:0] qw_c;
	logic [19:0] vq_c;

	assign e_full = {1'b0, interp_count_q} + 5'd1;
	assign e_val  = (e_full > EW'(EMAX)) ? EW'(EMAX) : e_full;
	assign t_val  = {1'b0, encoder_max_q} + 17'd1;

	assign din.ready = (state_q == ST_IDLE);
	assign acc_in    = din.valid && din.ready;
	assign emit      = (state_q == ST_N3) && (!out_valid_q || dout.ready);
	assign mem_we    = (state_q == ST_UPD) && in_store_q &&
		((mode_eff_q == MODE_PASS) || (mode_eff_q == MODE_INTERP));

	assign mreq.start = acc_in;
	assign mreq.a     = din.azimuth;
	assign mreq.b     = prior_az_q;
	assign mreq.t     = t_val;

	rpli_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// mode decision and unwrap
	always_comb begin
		n_ext    = {1'b0, mrsp.ra};
		o_ext    = {1'b0, mrsp.rb};
		wrap_neg = n_ext < o_ext;
		d_c      = wrap_neg ? (n_ext + t_val - o_ext) : (n_ext - o_ext);
		os_c     = wrap_neg ? ($signed({1'b0, o_ext}) - $signed({1'b0, t_val}))
			: $signed({1'b0, o_ext});
		drop_c   = {d_c, 1'b0} > {1'b0, t_val};
		if (mode_q != MODE_DECIDE) begin
			mode_c = mode_q;
		end else if (!have_prior_q) begin
			mode_c = MODE_PASS;
		end else if (drop_c) begin
			mode_c = MODE_DROP;
		end else begin
			mode_c = MODE_INTERP;
		end
	end

	// blend numerators
	always_comb begin
		ek     = e_q - k_q;
		pv     = $signed({1'b0, ek}) * (in_store_q ? rdata_q : 16'sd0);
		ps     = $signed({1'b0, k_q}) * s_q;
		vsum   = 23'(pv) + 23'(ps);
		vabs_c = vsum[22] ? 23'(-vsum) : 23'(vsum);
		naz_c  = 25'(os_q) * 25'($signed({1'b0, e_q})) +
			25'($signed({1'b0, d_q})) * 25'($signed({1'b0, k_q}));
		naz_w  = naz_c[24] ? naz_c + $signed({3'b000, te_q}) : naz_c;
	end

	always_comb begin
		m_c  = recip(e_q);
		qv_p = 45'(vabs_s1) * 45'(m_c);
		qa_p = 45'(naz_s1) * 45'(m_c);
	end

	// remainder, round half even, wrap
	always_comb begin
		rem_full = naz_s1 - 20'(qa_s2) * 20'(e_q);
		rem_c    = rem_full[EW-1:0];
		if (({1'b0, rem_c} << 1) > {1'b0, e_q} ||
			(({1'b0, rem_c} << 1) == {1'b0, e_q} && qa_s2[0])) begin
			qr_c = qa_s2 + 17'd1;
		end else begin
			qr_c = qa_s2;
		end
		qw_c = (qr_c >= t_q) ? qr_c - t_q : qr_c;
		vq_c = vneg_s1 ? -qv_s2 : qv_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			interp_count_q <= 4'd1;
			encoder_max_q  <= 16'hFFFF;
			prior_az_q     <= '0;
			have_prior_q   <= 1'b0;
			pos_q          <= '0;
			mode_q         <= MODE_DECIDE;
			out_valid_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_INTERP_COUNT: interp_count_q <= wr_data[3:0];
					REG_ENCODER_MAX:  encoder_max_q  <= wr_data;
					default: ;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						state_q <= ST_MODW;
					end
				end
				ST_MODW: begin
					if (mrsp.done) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					unique case (mode_c)
						MODE_PASS:   state_q <= ST_N3;
						MODE_INTERP: state_q <= ST_N1;
						default:     state_q <= ST_UPD;
					endcase
				end
				ST_N1: state_q <= ST_N2;
				ST_N2: state_q <= ST_N3;
				ST_N3: begin
					if (emit) begin
						if (mode_eff_q == MODE_PASS || k_q == e_q) begin
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_N1;
						end
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					if (pend_q && (mode_eff_q == MODE_PASS || mode_eff_q == MODE_INTERP)) begin
						prior_az_q   <= az_q;
						have_prior_q <= 1'b1;
					end
					if (pend_q) begin
						pos_q  <= '0;
						mode_q <= MODE_DECIDE;
					end else begin
						mode_q <= mode_eff_q;
						if (in_store_q) begin
							pos_q <= pos_q + PW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			s_q        <= din.sample;
			az_q       <= din.azimuth;
			pend_q     <= din.pulse_end;
			in_store_q <= pos_q < PW'(MAX_SAMPLES);
			rdata_q    <= line_mem[pos_q[AW-1:0]];
		end
		if (mem_we) begin
			line_mem[pos_q[AW-1:0]] <= s_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DEC) begin
			mode_eff_q <= mode_c;
			os_q       <= os_c;
			d_q        <= d_c;
			t_q        <= t_val;
			te_q       <= 22'(t_val) * 22'(e_val);
			e_q        <= e_val;
			k_q        <= 5'd1;
		end else if (emit) begin
			k_q <= k_q + 5'd1;
		end
		if (state_q == ST_N1) begin
			vneg_s1 <= vsum[22];
			vabs_s1 <= vabs_c[19:0];
			naz_s1  <= naz_w[19:0];
		end
		if (state_q == ST_N2) begin
			qv_s2 <= qv_p[RECIP_SH+19:RECIP_SH];
			qa_s2 <= qa_p[RECIP_SH+16:RECIP_SH];
		end
		if (emit) begin
			out_pend_q <= pend_q;
			if (mode_eff_q == MODE_PASS) begin
				out_value_q <= s_q;
				out_az_q    <= az_q;
				out_copy_q  <= '0;
				out_last_q  <= 1'b1;
			end else begin
				out_value_q <= $signed(vq_c[15:0]);
				out_az_q    <= qw_c[15:0];
				out_copy_q  <= 4'(k_q - 5'd1);
				out_last_q  <= (k_q == e_q);
			end
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.value        = out_value_q;
	assign dout.out_azimuth  = out_az_q;
	assign dout.copy_index   = out_copy_q;
	assign dout.at_pulse_end = out_pend_q;
	assign dout.last         = out_last_q;
endmodule
`default_nettype wire

[hdl/rpli_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpli_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_value,
	input wire logic        out_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value))
		else $error("stalled result value changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an item");

	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !in_ready)
		else $error("input ready before all results of an item left");
endmodule

bind radar_pulse_linear_interpolator rpli_checker u_rpli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_value (dout.value),
	.out_last  (dout.last)
);
`default_nettype wire
